>>> hdl/heading_pid_antiwindup_core_defines.svh
// assertion helpers for the heading controller core
`ifndef HEADING_PID_ANTIWINDUP_CORE_DEFINES_SVH
`define HEADING_PID_ANTIWINDUP_CORE_DEFINES_SVH

// same-cycle implication, held off during reset
`define HPA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define HPA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/hpa_pkg.sv
`default_nettype none

package hpa_pkg;

  localparam int HEADING_W  = 16;
  localparam int RATE_W     = 32;
  localparam int MOMENT_W   = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // round(pi * 2^29)
  localparam logic [31:0] PI_Q29 = 32'd1686629713;

  // wide signed format for products and sums
  typedef logic signed [51:0] wide_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN     = 3'd0,
    REG_INTEG_GAIN    = 3'd1,
    REG_DERIV_GAIN    = 3'd2,
    REG_OUTPUT_LIMIT  = 3'd3,
    REG_INTEG_LIMIT   = 3'd4,
    REG_SAMPLE_PERIOD = 3'd5
  } reg_idx_t;

  localparam logic [31:0] PROP_GAIN_RST     = 32'd786432;
  localparam logic [31:0] INTEG_GAIN_RST    = 32'd6554;
  localparam logic [31:0] DERIV_GAIN_RST    = 32'd32768;
  localparam logic [30:0] OUTPUT_LIMIT_RST  = 31'd65536000;
  localparam logic [30:0] INTEG_LIMIT_RST   = 31'd6553600;
  localparam logic [16:0] SAMPLE_PERIOD_RST = 17'd6554;

  typedef struct packed {
    logic [31:0] prop_gain;
    logic [31:0] integ_gain;
    logic [31:0] deriv_gain;
    logic [30:0] output_limit;
    logic [30:0] integ_limit;
    logic [16:0] sample_period;
  } cfg_regs_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_ERR,
    OP_WB_ERR,
    OP_MUL_P,
    OP_WB_P,
    OP_MUL_D,
    OP_WB_D,
    OP_PD,
    OP_TENT,
    OP_MUL_KE,
    OP_WB_KE,
    OP_MUL_INC,
    OP_WB_INC,
    OP_ACC_SUM,
    OP_ACC_CLAMP,
    OP_RES_SUM,
    OP_RES
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic freeze;
  } dp_status_t;

  function automatic wide_t clamp_sym(wide_t v, logic [30:0] lim);
    wide_t lim_w;
    lim_w = wide_t'({21'b0, lim});
    if (v > lim_w) begin
      return lim_w;
    end else if (v < -lim_w) begin
      return -lim_w;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

>>> hdl/hpa_in_if.sv
`default_nettype none

interface hpa_in_if;
  import hpa_pkg::*;

  logic                        valid;
  logic                        ready;
  logic [HEADING_W-1:0]        heading_target;
  logic [HEADING_W-1:0]        heading_measured;
  logic signed [RATE_W-1:0]    turn_rate;

  modport source (output valid, heading_target, heading_measured, turn_rate, input ready);
  modport sink   (input valid, heading_target, heading_measured, turn_rate, output ready);
endinterface

`default_nettype wire

>>> hdl/hpa_out_if.sv
`default_nettype none

interface hpa_out_if;
  import hpa_pkg::*;

  logic                        valid;
  logic                        ready;
  logic signed [MOMENT_W-1:0]  moment_cmd;

  modport source (output valid, moment_cmd, input ready);
  modport sink   (input valid, moment_cmd, output ready);
endinterface

`default_nettype wire

>>> hdl/hpa_cfg_if.sv
`default_nettype none

interface hpa_cfg_if;
  import hpa_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hdl/hpa_regs.sv
`default_nettype none

module hpa_regs (
  input  wire               clk,
  input  wire               rst,
  hpa_cfg_if.sink           cfg,
  output hpa_pkg::cfg_regs_t regs
);
  import hpa_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.prop_gain     <= PROP_GAIN_RST;
      regs.integ_gain    <= INTEG_GAIN_RST;
      regs.deriv_gain    <= DERIV_GAIN_RST;
      regs.output_limit  <= OUTPUT_LIMIT_RST;
      regs.integ_limit   <= INTEG_LIMIT_RST;
      regs.sample_period <= SAMPLE_PERIOD_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_PROP_GAIN:     regs.prop_gain     <= cfg.data;
        REG_INTEG_GAIN:    regs.integ_gain    <= cfg.data;
        REG_DERIV_GAIN:    regs.deriv_gain    <= cfg.data;
        REG_OUTPUT_LIMIT:  regs.output_limit  <= cfg.data[30:0];
        REG_INTEG_LIMIT:   regs.integ_limit   <= cfg.data[30:0];
        REG_SAMPLE_PERIOD: regs.sample_period <= cfg.data[16:0];
        default: ;  // unknown index ignored
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hdl/hpa_dp.sv
`default_nettype none

module hpa_dp (
  input  wire                                   clk,
  input  wire                                   rst,
  input  hpa_pkg::dp_cmd_t                      cmd,
  output hpa_pkg::dp_status_t                   status,
  input  hpa_pkg::cfg_regs_t                    regs,
  input  wire [hpa_pkg::HEADING_W-1:0]          heading_target,
  input  wire [hpa_pkg::HEADING_W-1:0]          heading_measured,
  input  wire signed [hpa_pkg::RATE_W-1:0]      turn_rate,
  output logic signed [hpa_pkg::MOMENT_W-1:0]   moment_cmd
);
  import hpa_pkg::*;

  logic signed [15:0] diff;
  logic signed [31:0] rate;
  logic signed [18:0] err;
  logic signed [34:0] ke;
  wide_t              p;
  wide_t              d;
  wide_t              pd;
  wide_t              inc;
  wide_t              sum;
  logic signed [31:0] acc;
  logic signed [67:0] prod;

  logic [31:0]        mul_a;
  logic signed [34:0] mul_b;
  logic signed [67:0] prod_full;
  logic signed [67:0] rnd16_sum;
  logic signed [67:0] rnd28_sum;
  wide_t              rnd16;
  wide_t              acc_w;
  wide_t              olim_w;
  wide_t              acc_clamped;
  wide_t              out_clamped;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_MUL_ERR: begin
        mul_a = PI_Q29;
        mul_b = 35'(diff);
      end
      OP_MUL_P: begin
        mul_a = regs.prop_gain;
        mul_b = 35'(err);
      end
      OP_MUL_D: begin
        mul_a = regs.deriv_gain;
        mul_b = 35'(rate);
      end
      OP_MUL_KE: begin
        mul_a = regs.integ_gain;
        mul_b = 35'(err);
      end
      OP_MUL_INC: begin
        mul_a = 32'(regs.sample_period);
        mul_b = ke;
      end
      default: ;
    endcase
  end

  assign prod_full = $signed({1'b0, mul_a}) * mul_b;

  // round half up, then floor shift
  assign rnd16_sum   = prod + 68'sd32768;
  assign rnd28_sum   = prod + 68'sd134217728;
  assign rnd16       = $signed(rnd16_sum[67:16]);

  assign acc_w       = wide_t'(acc);
  assign olim_w      = wide_t'({21'b0, regs.output_limit});
  assign acc_clamped = clamp_sym(sum, regs.integ_limit);
  assign out_clamped = clamp_sym(sum, regs.output_limit);

  // tentative output saturated with the error's sign
  assign status.freeze = ((err > 19'sd0) && (sum > 52'sd0) && (sum >= olim_w)) ||
                         ((err < 19'sd0) && (sum < 52'sd0) && (sum <= -olim_w));

  always_ff @(posedge clk) begin
    case (cmd.op) inside
      OP_LOAD: begin
        diff <= $signed(heading_target - heading_measured);
        rate <= turn_rate;
      end
      OP_MUL_ERR, OP_MUL_P, OP_MUL_D, OP_MUL_KE, OP_MUL_INC: prod <= prod_full;
      OP_WB_ERR:  err <= $signed(rnd28_sum[46:28]);
      OP_WB_P:    p   <= rnd16;
      OP_WB_D:    d   <= rnd16;
      OP_WB_KE:   ke  <= rnd16[34:0];
      OP_WB_INC:  inc <= rnd16;
      OP_PD:      pd  <= p - d;
      OP_TENT, OP_RES_SUM: sum <= pd + acc_w;
      OP_ACC_SUM: sum <= acc_w + inc;
      OP_RES:     moment_cmd <= out_clamped[31:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (cmd.op == OP_ACC_CLAMP) begin
      acc <= acc_clamped[31:0];
    end
  end

endmodule

`default_nettype wire

>>> hdl/hpa_ctrl.sv
`default_nettype none

module hpa_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire                  out_ready,
  output hpa_pkg::dp_cmd_t     cmd,
  input  hpa_pkg::dp_status_t  status
);
  import hpa_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ERR_M,
    S_ERR_W,
    S_P_M,
    S_P_W,
    S_D_M,
    S_D_W,
    S_PD,
    S_TENT,
    S_CHK,
    S_KE_M,
    S_KE_W,
    S_INC_M,
    S_INC_W,
    S_ASUM,
    S_ACLMP,
    S_RSUM,
    S_RES
  } state_t;

  state_t state;
  logic   res_free;

  assign in_ready = (state == S_IDLE);
  assign res_free = !out_valid || out_ready;

  always_comb begin
    cmd.op = OP_NONE;
    unique case (state)
      S_IDLE:  if (in_valid) cmd.op = OP_LOAD;
      S_ERR_M: cmd.op = OP_MUL_ERR;
      S_ERR_W: cmd.op = OP_WB_ERR;
      S_P_M:   cmd.op = OP_MUL_P;
      S_P_W:   cmd.op = OP_WB_P;
      S_D_M:   cmd.op = OP_MUL_D;
      S_D_W:   cmd.op = OP_WB_D;
      S_PD:    cmd.op = OP_PD;
      S_TENT:  cmd.op = OP_TENT;
      S_CHK:   cmd.op = OP_NONE;
      S_KE_M:  cmd.op = OP_MUL_KE;
      S_KE_W:  cmd.op = OP_WB_KE;
      S_INC_M: cmd.op = OP_MUL_INC;
      S_INC_W: cmd.op = OP_WB_INC;
      S_ASUM:  cmd.op = OP_ACC_SUM;
      S_ACLMP: cmd.op = OP_ACC_CLAMP;
      S_RSUM:  cmd.op = OP_RES_SUM;
      S_RES:   if (res_free) cmd.op = OP_RES;
      default: cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == S_RES && res_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE:  if (in_valid) state <= S_ERR_M;
        S_ERR_M: state <= S_ERR_W;
        S_ERR_W: state <= S_P_M;
        S_P_M:   state <= S_P_W;
        S_P_W:   state <= S_D_M;
        S_D_M:   state <= S_D_W;
        S_D_W:   state <= S_PD;
        S_PD:    state <= S_TENT;
        S_TENT:  state <= S_CHK;
        S_CHK:   state <= status.freeze ? S_RSUM : S_KE_M;
        S_KE_M:  state <= S_KE_W;
        S_KE_W:  state <= S_INC_M;
        S_INC_M: state <= S_INC_W;
        S_INC_W: state <= S_ASUM;
        S_ASUM:  state <= S_ACLMP;
        S_ACLMP: state <= S_RSUM;
        S_RSUM:  state <= S_RES;
        S_RES:   if (res_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hdl/heading_pid_antiwindup_core.sv
// heading autopilot pid core with conditional-integration anti-windup
//
// channels: sample (heading_target, heading_measured, turn_rate) in, result
// (moment_cmd) out, both valid/ready; cfg is a valid/ready register write
// channel (index, data), always ready, one register per transaction
// each sample runs through one shared 33x35 multiplier; each product is registered
// and then rounded and written back in its own step, sequenced by the controller
// a sample runs through the steps in order; when the integrator is frozen the
// integrator update steps are skipped
// samples are processed one at a time, no new sample before the last is through;
// sample ready is high only while the sequencer is idle
// the result sits in an output register, so a new sample is taken while the
// previous result still waits; if the receiver stalls, the next result waits
// in its last step until the output register frees up
// reset (rst, synchronous): registers back to defaults, integrator cleared,
// no result pending
`default_nettype none
`include "heading_pid_antiwindup_core_defines.svh"

module heading_pid_antiwindup_core (
  input  wire      clk,
  input  wire      rst,
  hpa_cfg_if.sink  cfg,
  hpa_in_if.sink   sample,
  hpa_out_if.source result
);
  import hpa_pkg::*;

  cfg_regs_t  cfg_regs;
  dp_cmd_t    ctrl_cmd;
  dp_status_t dp_status;

  // register file for gains, limits and period
  hpa_regs u_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (cfg_regs)
  );

  // step sequencer and result handshake
  hpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (ctrl_cmd),
    .status    (dp_status)
  );

  // error, pd, integrator and saturation arithmetic
  hpa_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (ctrl_cmd),
    .status           (dp_status),
    .regs             (cfg_regs),
    .heading_target   (sample.heading_target),
    .heading_measured (sample.heading_measured),
    .turn_rate        (sample.turn_rate),
    .moment_cmd       (result.moment_cmd)
  );

  // checks
  logic              smp_xact;
  logic signed [32:0] moment_ext;
  logic signed [32:0] olim_ext;
  logic              moment_ok;

  assign smp_xact   = sample.valid && sample.ready;
  assign moment_ext = 33'(result.moment_cmd);
  assign olim_ext   = $signed({2'b0, cfg_regs.output_limit});
  assign moment_ok  = (moment_ext <= olim_ext) && (moment_ext >= -olim_ext);

  // one sample in flight: busy right after a sample transaction
  `HPA_ASSERT_NEXT(a_busy_after_take, clk, rst, smp_xact, !sample.ready, "sample taken while busy")
  // the datapath loads operands exactly on a sample transaction
  `HPA_ASSERT_SAME(a_load_on_take, clk, rst, smp_xact, ctrl_cmd.op == OP_LOAD, "sample not loaded")
  // a written result is presented next cycle
  `HPA_ASSERT_NEXT(a_res_shown, clk, rst, ctrl_cmd.op == OP_RES, result.valid, "result dropped")
  // presented moment respects the saturation limit
  `HPA_ASSERT_SAME(a_moment_sat, clk, rst, result.valid, moment_ok, "moment beyond limit")

endmodule

`default_nettype wire
